[src/rsa_pkg.sv]
// Shared types and constants for the running stream aggregator.
`default_nettype none

package rsa_pkg;

  localparam int AccWidth      = 64;
  localparam int OutCountWidth = 32;
  localparam int ModeWidth     = 3;
  localparam int KindWidth     = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_SUM   = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_COUNT = 3'd2,
    MODE_MAX   = 3'd3,
    MODE_MIN   = 3'd4,
    MODE_FIRST = 3'd5,
    MODE_LAST  = 3'd6
  } agg_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

[src/rsa_div.sv]
// Radix-2 restoring divider: signed dividend by an unsigned count, truncating toward zero.
`default_nettype none

module rsa_div #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [rsa_pkg::AccWidth-1:0]   dividend_i,
  input  wire logic [COUNT_WIDTH-1:0]         divisor_i,
  output logic                                done_o,
  output logic [rsa_pkg::AccWidth-1:0]        quotient_o
);

  localparam int StepWidth = $clog2(rsa_pkg::AccWidth);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic                            neg_q, neg_d;
  logic [StepWidth-1:0]            cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]          rem_q, rem_d;
  logic [COUNT_WIDTH-1:0]          dvs_q, dvs_d;
  logic [rsa_pkg::AccWidth-1:0]    quo_q, quo_d;
  logic [COUNT_WIDTH:0]            trial;
  logic [COUNT_WIDTH:0]            diff;
  logic                            fits;

  assign trial = {rem_q, quo_q[rsa_pkg::AccWidth-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[rsa_pkg::AccWidth-1];
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i[rsa_pkg::AccWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      quo_d = {quo_q[rsa_pkg::AccWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepWidth'(rsa_pkg::AccWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

[src/running_stream_aggregator_top.sv]
// Top level of the running stream aggregator: state update, sequencer and output register.
// A word that needs no division passes from acceptance through the EVAL and OUT states
// to the output register; no new word is taken until the sequencer is back in IDLE.
// A word in average mode with a value present and a non-zero count also runs the radix-2
// divider in the DIV state before OUT; in OUT a held-up receiver stalls the sequencer.
// The asynchronous active-low reset clears the aggregate, count, flags and mode (sum).
`default_nettype none

module running_stream_aggregator_top #(
  parameter  int VALUE_WIDTH = 48,
  parameter  int COUNT_WIDTH = 32,
  localparam int SDataWidth  = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [rsa_pkg::ModeWidth-1:0] cfg_data_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // Bits: sample_value, then zero padding.
  input  wire logic [SDataWidth-1:0]   s_axis_tdata,
  // Bits: kind.
  input  wire logic [rsa_pkg::KindWidth-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // Bits: agg_value, event_count.
  output logic [rsa_pkg::AccWidth+rsa_pkg::OutCountWidth-1:0] m_axis_tdata,
  // Bits: has_value, saturated.
  output logic [1:0]                   m_axis_tuser
);

  localparam int AccW = rsa_pkg::AccWidth;

  rsa_pkg::seq_state_e     state_q, state_d;
  rsa_pkg::agg_mode_e      mode_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    present_q, present_d;
  logic [COUNT_WIDTH-1:0]  tally_q, tally_d;
  logic                    ovf_q, ovf_d;
  logic                    avg_q, avg_d;
  logic                    m_valid_q, m_valid_d;
  logic [AccW+rsa_pkg::OutCountWidth-1:0] m_data_q;
  logic [1:0]              m_user_q;

  logic                    in_ready;
  logic                    accept;
  logic                    div_start;
  logic                    div_done;
  logic [AccW-1:0]         quotient;
  logic                    out_load;
  logic signed [AccW-1:0]  sample;
  logic signed [AccW-1:0]  sum;
  logic                    sum_ovf;
  logic [COUNT_WIDTH-1:0]  tally_bump;
  logic                    tally_full;
  logic [AccW-1:0]         result;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && in_ready;

  assign sample = {{(AccW - VALUE_WIDTH){s_axis_tdata[VALUE_WIDTH-1]}},
                   s_axis_tdata[VALUE_WIDTH-1:0]};
  assign sum     = acc_q + sample;
  assign sum_ovf = (acc_q[AccW-1] == sample[AccW-1]) && (sum[AccW-1] != acc_q[AccW-1]);
  assign tally_full = &tally_q;
  assign tally_bump = tally_full ? tally_q : tally_q + 1'b1;

  always_comb begin
    acc_d     = acc_q;
    present_d = present_q;
    tally_d   = tally_q;
    ovf_d     = ovf_q;
    avg_d     = avg_q;
    if (accept) begin
      case (rsa_pkg::kind_e'(s_axis_tuser))
        rsa_pkg::KIND_ADD: begin
          unique case (mode_q)
            rsa_pkg::MODE_SUM, rsa_pkg::MODE_AVG: begin
              if (!present_q) begin
                acc_d = sample;
              end else if (sum_ovf) begin
                acc_d = acc_q[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
              end else begin
                acc_d = sum;
              end
              ovf_d     = ovf_q | (present_q && sum_ovf) | tally_full;
              present_d = 1'b1;
              tally_d   = tally_bump;
            end
            rsa_pkg::MODE_COUNT: begin
              tally_d   = tally_bump;
              ovf_d     = ovf_q | tally_full;
              acc_d     = AccW'(tally_bump);
              present_d = 1'b1;
            end
            rsa_pkg::MODE_MAX: begin
              if (!present_q || sample > acc_q) begin
                acc_d = sample;
              end
              present_d = 1'b1;
              tally_d   = tally_bump;
              ovf_d     = ovf_q | tally_full;
            end
            rsa_pkg::MODE_MIN: begin
              if (!present_q || sample < acc_q) begin
                acc_d = sample;
              end
              present_d = 1'b1;
              tally_d   = tally_bump;
              ovf_d     = ovf_q | tally_full;
            end
            rsa_pkg::MODE_FIRST: begin
              if (!present_q) begin
                acc_d     = sample;
                present_d = 1'b1;
                tally_d   = COUNT_WIDTH'(1);
              end
            end
            rsa_pkg::MODE_LAST: begin
              acc_d     = sample;
              present_d = 1'b1;
              tally_d   = tally_bump;
              ovf_d     = ovf_q | tally_full;
            end
            default: begin
              acc_d = acc_q;
            end
          endcase
        end
        rsa_pkg::KIND_CLEAR: begin
          acc_d     = '0;
          present_d = 1'b0;
          tally_d   = '0;
          ovf_d     = 1'b0;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      avg_d = present_d && (mode_q == rsa_pkg::MODE_AVG) && (tally_d != '0);
    end
  end

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      rsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = rsa_pkg::ST_EVAL;
        end
      end
      rsa_pkg::ST_EVAL: begin
        if (avg_q) begin
          div_start = 1'b1;
          state_d   = rsa_pkg::ST_DIV;
        end else begin
          state_d = rsa_pkg::ST_OUT;
        end
      end
      rsa_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = rsa_pkg::ST_OUT;
        end
      end
      rsa_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = rsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsa_pkg::ST_IDLE;
      end
    endcase
  end

  rsa_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (tally_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign result = !present_q ? '0 : (avg_q ? quotient : acc_q);

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsa_pkg::ST_IDLE;
      mode_q    <= rsa_pkg::MODE_SUM;
      acc_q     <= '0;
      present_q <= 1'b0;
      tally_q   <= '0;
      ovf_q     <= 1'b0;
      avg_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i) begin
        mode_q <= rsa_pkg::agg_mode_e'(cfg_data_i);
      end
      acc_q     <= acc_d;
      present_q <= present_d;
      tally_q   <= tally_d;
      ovf_q     <= ovf_d;
      avg_q     <= avg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {rsa_pkg::OutCountWidth'(tally_q), result};
      m_user_q <= {ovf_q, present_q};
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire
